@@ sv/peer_admission_policer_table_unit_macros.svh @@
// Assertion macros for the checker file
`ifndef PEER_ADMISSION_POLICER_TABLE_UNIT_MACROS_SVH
`define PEER_ADMISSION_POLICER_TABLE_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define PAPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("peer admission check failed");
// Next-cycle implication checked outside reset
`define PAPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("peer admission check failed");
`endif

@@ sv/papt_pkg.sv @@
// Package with opcodes, denial codes and constants of the peer policer table
`default_nettype none
package papt_pkg;
    typedef enum logic [2:0] {
        FN_OPEN_TCP  = 3'd0,
        FN_CLOSE_TCP = 3'd1,
        FN_REQUEST   = 3'd2,
        FN_UPGRADE   = 3'd3,
        FN_OPEN_WS   = 3'd4,
        FN_CLOSE_WS  = 3'd5
    } func_t;

    localparam logic [1:0] DEN_NONE = 2'd0;
    localparam logic [1:0] DEN_RATE = 2'd1;
    localparam logic [1:0] DEN_CONN = 2'd2;

    localparam logic [2:0] REG_HTTP_CAP  = 3'd0;
    localparam logic [2:0] REG_HTTP_RATE = 3'd1;
    localparam logic [2:0] REG_UPG_CAP   = 3'd2;
    localparam logic [2:0] REG_UPG_RATE  = 3'd3;
    localparam logic [2:0] REG_TCP_TOT   = 3'd4;
    localparam logic [2:0] REG_WS_TOT    = 3'd5;
    localparam logic [2:0] REG_WS_PEER   = 3'd6;
    localparam logic [2:0] REG_IDLE      = 3'd7;

    localparam logic [15:0] CONN_RETRY_MS = 16'd1000;
    localparam logic [24:0] ONE_TOKEN     = 25'h010000;

    // One table entry as stored in memory
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] seen;
        logic [9:0]  tcp;
        logic [9:0]  ws;
        logic [23:0] rtok;
        logic [31:0] rms;
        logic [23:0] utok;
        logic [31:0] ums;
    } entry_t;

    // Request to the divider
    typedef struct packed {
        logic        start;
        logic [41:0] num;
        logic [23:0] den;
    } div_req_t;
endpackage
`default_nettype wire

@@ sv/papt_div.sv @@
// Restoring divider, one quotient bit per cycle
`default_nettype none
module papt_div
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire papt_pkg::div_req_t req,
    output logic                   busy,
    output logic [41:0]            quo,
    output logic [41:0]            rem
);
    import papt_pkg::*;

    logic [41:0] q_reg;
    logic [41:0] r_reg;
    logic [23:0] d_reg;
    logic [5:0]  cnt_reg;
    logic [42:0] trial;

    assign trial = {r_reg, q_reg[41]} - {19'd0, d_reg};
    assign busy  = (cnt_reg != 6'd0);
    assign quo   = q_reg;
    assign rem   = r_reg;

    // Shift in one numerator bit per cycle, subtract when it fits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (req.start)
        begin
            q_reg   <= req.num;
            r_reg   <= '0;
            d_reg   <= req.den;
            cnt_reg <= 6'd42;
        end
        else if (busy)
        begin
            if (!trial[42])
            begin
                r_reg <= trial[41:0];
                q_reg <= {q_reg[40:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[40:0], q_reg[41]};
                q_reg <= {q_reg[40:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 6'd1;
        end
    end
endmodule
`default_nettype wire

@@ sv/peer_admission_policer_table_unit.sv @@
// Top level of the peer admission policer table
//
//  channel | direction | handshake      | payload
//  in      | input     | in_valid/stall | func, peer_key, now_ms
//  out     | output    | out_valid/stall| accepted, denial, retry_after_ms, limit_hit
//  cfg     | input     | cfg_we         | cfg_index, cfg_data
//
// One item at a time. A connection item shows its result after a prune sweep and a
// lookup sweep over the single-port table memory; a TCP limit denial skips the lookup
// sweep. Request/upgrade add the token refill and, for a rate denial, the retry division.
// Closes run the lookup sweep, write back a known peer and give no result. No clearing
// pass: valid bits sit in flip-flops cleared by reset. A result waits in the output
// register while out_stall is high; the next item is taken once it has been delivered.
`default_nettype none
module peer_admission_policer_table_unit
#(
    parameter int PEER_ENTRIES = 64,
    parameter int MAX_RETRY_MS = 60000
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  func,
    input  wire logic [63:0] peer_key,
    input  wire logic [31:0] now_ms,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             accepted,
    output logic [1:0]       denial,
    output logic [15:0]      retry_after_ms,
    output logic [15:0]      limit_hit,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import papt_pkg::*;

    localparam int AW = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] LAST = CW'(PEER_ENTRIES - 1);
    localparam logic [15:0] ENTRIES16 = 16'(PEER_ENTRIES);
    localparam logic [15:0] MAXR16 = 16'(MAX_RETRY_MS);
    // Refill gain reaches 2^24 (256 tokens, above any cap) from this dt*rate on
    localparam logic [47:0] REFILL_SAT = 48'd65536000;
    // ceil(2^38 / 125): floor(n / 125) = (n * RECIP_125) >> 38 for n < 2^31
    localparam logic [31:0] RECIP_125 = 32'd2199023256;

    typedef enum logic [3:0] {
        S_IDLE, S_PRUNE, S_CHECK, S_FIND, S_PLACE, S_ACT,
        S_REFILL, S_TAKE, S_RETRY, S_FINISH, S_OUT
    } state_t;

    // Configuration registers
    logic [7:0]  hcap_reg, ucap_reg;
    logic [15:0] hrate_reg, urate_reg;
    logic [9:0]  tcpl_reg, wstl_reg, wspl_reg;
    logic [31:0] idle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcap_reg <= 8'd20;
            hrate_reg <= 16'd2560;
            ucap_reg <= 8'd5;
            urate_reg <= 16'd256;
            tcpl_reg <= 10'd256;
            wstl_reg <= 10'd128;
            wspl_reg <= 10'd4;
            idle_reg <= 32'd60000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HTTP_CAP:  hcap_reg <= cfg_data[7:0];
                REG_HTTP_RATE: hrate_reg <= cfg_data[15:0];
                REG_UPG_CAP:   ucap_reg <= cfg_data[7:0];
                REG_UPG_RATE:  urate_reg <= cfg_data[15:0];
                REG_TCP_TOT:   tcpl_reg <= cfg_data[9:0];
                REG_WS_TOT:    wstl_reg <= cfg_data[9:0];
                REG_WS_PEER:   wspl_reg <= cfg_data[9:0];
                REG_IDLE:      idle_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Table memory, one port, registered read
    entry_t mem [PEER_ENTRIES];
    entry_t rd_reg;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    logic [PEER_ENTRIES-1:0] valid_reg;

    // Divider
    div_req_t dreq;
    logic dbusy;
    logic [41:0] dquo, drem;
    papt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quo(dquo), .rem(drem));

    state_t state_reg;
    logic [2:0] fn_reg;
    logic [63:0] key_reg;
    logic [31:0] now_reg;
    logic [CW-1:0] cnt_reg;      // sweep address issued
    logic          rv_reg;       // read data valid for address pa_reg
    logic [AW-1:0] pa_reg;
    logic [9:0] tcpt_reg, wst_reg;
    logic hit_reg, free_reg, ev_reg;
    logic [AW-1:0] hit_a_reg, free_a_reg, ev_a_reg;
    logic [31:0] ev_seen_reg;
    logic [63:0] ev_key_reg;
    entry_t cur_reg;
    logic [AW-1:0] slot_reg;
    logic [1:0] phase_reg;
    logic [23:0] tok_reg;
    logic        acc_reg;
    logic [1:0]  den_reg;
    logic [15:0] retry_reg, lim_reg;
    logic        out_valid_reg;

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign accepted = acc_reg;
    assign denial = den_reg;
    assign retry_after_ms = retry_reg;
    assign limit_hit = lim_reg;

    // Bucket helpers for the selected func
    logic is_req;
    logic [7:0]  cap_sel;
    logic [15:0] rate_sel;
    logic [23:0] btok;
    logic [31:0] bms;
    logic [24:0] capq;
    logic [31:0] dt;
    assign is_req   = (fn_reg == FN_REQUEST);
    assign cap_sel  = is_req ? hcap_reg : ucap_reg;
    assign rate_sel = is_req ? hrate_reg : urate_reg;
    assign btok     = is_req ? cur_reg.rtok : cur_reg.utok;
    assign bms      = is_req ? cur_reg.rms : cur_reg.ums;
    assign capq     = {1'b0, cap_sel, 16'd0};
    assign dt       = now_reg - bms;

    // Refill: dt*rate, then *256/1000 as *32/125 by reciprocal multiply
    logic [47:0] prod_reg;
    logic        sat_reg;
    logic [30:0] scaled_reg;
    logic [62:0] recip_reg;
    logic [24:0] gain;
    logic [24:0] fill_sum;
    assign gain     = recip_reg[62:38];
    assign fill_sum = {1'b0, tok_reg} + gain;

    // Retry numerator (1.0 - tokens) * 1000, tokens below one token here
    logic [16:0] short_tok;
    logic [25:0] rnum;
    assign short_tok = ONE_TOKEN[16:0] - tok_reg[16:0];
    assign rnum      = {9'd0, short_tok} * 26'd1000;

    logic adm;
    logic [AW-1:0] free_pick;
    assign adm = rd_reg.tcp == 10'd0 && rd_reg.ws == 10'd0;

    always_comb
    begin
        raddr = cnt_reg[AW-1:0];
        we = (state_reg == S_FINISH);
        waddr = slot_reg;
        wdata = cur_reg;
        free_pick = free_a_reg;
        dreq.start = (state_reg == S_RETRY) && (phase_reg == 2'd0);
        dreq.num = {16'd0, rnum};
        dreq.den = {rate_sel, 8'd0};
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            tcpt_reg <= '0;
            wst_reg <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg <= '0;
            rv_reg <= 1'b0;
            phase_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        fn_reg <= func;
                        key_reg <= peer_key;
                        now_reg <= now_ms;
                        cnt_reg <= '0;
                        rv_reg <= 1'b0;
                        hit_reg <= 1'b0;
                        free_reg <= 1'b0;
                        ev_reg <= 1'b0;
                        if (func == FN_CLOSE_TCP || func == FN_CLOSE_WS)
                            state_reg <= S_FIND;
                        else if (func <= FN_OPEN_WS)
                            state_reg <= S_PRUNE;
                    end
                end
                S_PRUNE:
                begin
                    // drop idle connectionless entries, one per cycle
                    if (rv_reg && valid_reg[pa_reg] && adm && now_reg >= rd_reg.seen &&
                        now_reg - rd_reg.seen >= idle_reg)
                        valid_reg[pa_reg] <= 1'b0;
                    pa_reg <= cnt_reg[AW-1:0];
                    rv_reg <= (cnt_reg <= LAST);
                    if (cnt_reg <= LAST)
                        cnt_reg <= cnt_reg + 1'b1;
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    cnt_reg <= '0;
                    rv_reg <= 1'b0;
                    if (fn_reg == FN_OPEN_TCP && tcpt_reg >= tcpl_reg)
                    begin
                        acc_reg <= 1'b0;
                        den_reg <= DEN_CONN;
                        retry_reg <= CONN_RETRY_MS;
                        lim_reg <= {6'd0, tcpl_reg};
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_FIND;
                end
                S_FIND:
                begin
                    // search for key, first free slot and eviction victim
                    if (rv_reg)
                    begin
                        if (valid_reg[pa_reg])
                        begin
                            if (rd_reg.key == key_reg && !hit_reg)
                            begin
                                hit_reg <= 1'b1;
                                hit_a_reg <= pa_reg;
                                cur_reg <= rd_reg;
                            end
                            if (adm && (!ev_reg || rd_reg.seen < ev_seen_reg ||
                                (rd_reg.seen == ev_seen_reg && rd_reg.key < ev_key_reg)))
                            begin
                                ev_reg <= 1'b1;
                                ev_a_reg <= pa_reg;
                                ev_seen_reg <= rd_reg.seen;
                                ev_key_reg <= rd_reg.key;
                            end
                        end
                        else if (!free_reg)
                        begin
                            free_reg <= 1'b1;
                            free_a_reg <= pa_reg;
                        end
                    end
                    pa_reg <= cnt_reg[AW-1:0];
                    rv_reg <= (cnt_reg <= LAST);
                    if (cnt_reg <= LAST)
                        cnt_reg <= cnt_reg + 1'b1;
                    else
                        state_reg <= S_PLACE;
                end
                S_PLACE:
                begin
                    if (hit_reg)
                    begin
                        slot_reg <= hit_a_reg;
                        cur_reg.seen <= now_reg;
                        state_reg <= S_ACT;
                    end
                    else if (fn_reg == FN_CLOSE_TCP || fn_reg == FN_CLOSE_WS)
                        state_reg <= S_IDLE;
                    else if (free_reg || ev_reg)
                    begin
                        slot_reg <= free_reg ? free_pick : ev_a_reg;
                        valid_reg[free_reg ? free_pick : ev_a_reg] <= 1'b1;
                        cur_reg.key <= key_reg;
                        cur_reg.seen <= now_reg;
                        cur_reg.tcp <= '0;
                        cur_reg.ws <= '0;
                        cur_reg.rtok <= {hcap_reg, 16'd0};
                        cur_reg.rms <= now_reg;
                        cur_reg.utok <= {ucap_reg, 16'd0};
                        cur_reg.ums <= now_reg;
                        state_reg <= S_ACT;
                    end
                    else
                    begin
                        acc_reg <= 1'b0;
                        den_reg <= DEN_CONN;
                        retry_reg <= CONN_RETRY_MS;
                        lim_reg <= ENTRIES16;
                        state_reg <= S_OUT;
                    end
                end
                S_ACT:
                begin
                    acc_reg <= 1'b1;
                    den_reg <= DEN_NONE;
                    retry_reg <= '0;
                    lim_reg <= '0;
                    state_reg <= S_FINISH;
                    case (fn_reg)
                        FN_CLOSE_TCP:
                        begin
                            if (cur_reg.tcp != 10'd0)
                            begin
                                cur_reg.tcp <= cur_reg.tcp - 10'd1;
                                if (tcpt_reg != 10'd0)
                                    tcpt_reg <= tcpt_reg - 10'd1;
                            end
                        end
                        FN_CLOSE_WS:
                        begin
                            if (cur_reg.ws != 10'd0)
                            begin
                                cur_reg.ws <= cur_reg.ws - 10'd1;
                                if (wst_reg != 10'd0)
                                    wst_reg <= wst_reg - 10'd1;
                            end
                        end
                        FN_OPEN_TCP:
                        begin
                            cur_reg.tcp <= cur_reg.tcp + 10'd1;
                            tcpt_reg <= tcpt_reg + 10'd1;
                        end
                        FN_OPEN_WS:
                        begin
                            if (wst_reg >= wstl_reg)
                            begin
                                acc_reg <= 1'b0;
                                den_reg <= DEN_CONN;
                                retry_reg <= CONN_RETRY_MS;
                                lim_reg <= {6'd0, wstl_reg};
                            end
                            else if (cur_reg.ws >= wspl_reg)
                            begin
                                acc_reg <= 1'b0;
                                den_reg <= DEN_CONN;
                                retry_reg <= CONN_RETRY_MS;
                                lim_reg <= {6'd0, wspl_reg};
                            end
                            else
                            begin
                                cur_reg.ws <= cur_reg.ws + 10'd1;
                                wst_reg <= wst_reg + 10'd1;
                            end
                        end
                        default:
                        begin
                            // request or upgrade: form refill product
                            prod_reg <= {16'd0, dt} * {32'd0, rate_sel};
                            tok_reg <= btok;
                            phase_reg <= 2'd0;
                            state_reg <= S_REFILL;
                        end
                    endcase
                end
                S_REFILL:
                begin
                    case (phase_reg)
                        2'd0:
                        begin
                            if (now_reg > bms)
                            begin
                                sat_reg <= (prod_reg >= REFILL_SAT);
                                scaled_reg <= {prod_reg[25:0], 5'd0};
                                phase_reg <= 2'd1;
                            end
                            else
                                state_reg <= S_TAKE;
                        end
                        2'd1:
                        begin
                            recip_reg <= {32'd0, scaled_reg} * {31'd0, RECIP_125};
                            phase_reg <= 2'd2;
                        end
                        default:
                        begin
                            // add the gain and cap at capacity
                            if (sat_reg || fill_sum >= capq)
                                tok_reg <= capq[23:0];
                            else
                                tok_reg <= fill_sum[23:0];
                            if (is_req)
                                cur_reg.rms <= now_reg;
                            else
                                cur_reg.ums <= now_reg;
                            state_reg <= S_TAKE;
                        end
                    endcase
                end
                S_TAKE:
                begin
                    phase_reg <= 2'd0;
                    if ({1'b0, tok_reg} >= ONE_TOKEN)
                    begin
                        if (is_req)
                            cur_reg.rtok <= tok_reg - ONE_TOKEN[23:0];
                        else
                            cur_reg.utok <= tok_reg - ONE_TOKEN[23:0];
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        if (is_req)
                            cur_reg.rtok <= tok_reg;
                        else
                            cur_reg.utok <= tok_reg;
                        acc_reg <= 1'b0;
                        den_reg <= DEN_RATE;
                        lim_reg <= '0;
                        if (rate_sel == 16'd0)
                        begin
                            retry_reg <= MAXR16;
                            state_reg <= S_FINISH;
                        end
                        else
                            state_reg <= S_RETRY;
                    end
                end
                S_RETRY:
                begin
                    case (phase_reg)
                        2'd0: phase_reg <= 2'd1;
                        2'd1: phase_reg <= 2'd2;
                        default:
                        begin
                            if (!dbusy)
                            begin
                                if (dquo[41:16] != 26'd0 ||
                                    dquo[15:0] + {15'd0, drem != 42'd0} > MAXR16 ||
                                    dquo[15:0] == 16'hFFFF)
                                    retry_reg <= MAXR16;
                                else if (dquo[15:0] + {15'd0, drem != 42'd0} == 16'd0)
                                    retry_reg <= 16'd1;
                                else
                                    retry_reg <= dquo[15:0] + {15'd0, drem != 42'd0};
                                state_reg <= S_FINISH;
                            end
                        end
                    endcase
                end
                S_FINISH:
                begin
                    // write back the entry and report for admitting funcs
                    if (fn_reg == FN_CLOSE_TCP || fn_reg == FN_CLOSE_WS)
                        state_reg <= S_IDLE;
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ sv/papt_checker.sv @@
// Port-level checker for the peer policer table, bound to the top level
`default_nettype none
`include "peer_admission_policer_table_unit_macros.svh"
module papt_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        accepted,
    input wire logic [1:0]  denial,
    input wire logic [15:0] retry_after_ms,
    input wire logic [15:0] limit_hit
);
    import papt_pkg::*;
    `PAPT_ASSERT_IMPL(a_acc_clean, clk, rst_n, out_valid && accepted,
        denial == DEN_NONE && retry_after_ms == 16'd0 && limit_hit == 16'd0)
    `PAPT_ASSERT_IMPL(a_deny_code, clk, rst_n, out_valid && !accepted,
        denial == DEN_RATE || denial == DEN_CONN)
    `PAPT_ASSERT_IMPL(a_conn_retry, clk, rst_n, out_valid && denial == DEN_CONN,
        retry_after_ms == CONN_RETRY_MS)
    `PAPT_ASSERT_IMPL(a_one_item, clk, rst_n, out_valid, in_stall)
    `PAPT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(accepted) && $stable(retry_after_ms))
endmodule

bind peer_admission_policer_table_unit papt_checker u_papt_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
    .denial(denial), .retry_after_ms(retry_after_ms), .limit_hit(limit_hit)
);
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the peer admission policer table unit
`default_nettype none
module tb_top;
    import papt_pkg::*;

    localparam int        TABLE_SLOTS = 64;
    localparam int        RETRY_CAP   = 60000;
    localparam int        SETTLE_CYC  = 300;
    localparam int        CYCLE_LIMIT = 2500000;
    localparam logic [2:0] FN_SPARE_6 = 3'd6;
    localparam logic [2:0] FN_SPARE_7 = 3'd7;

    typedef struct packed {
        logic        acc;
        logic [1:0]  den;
        logic [15:0] retry;
        logic [15:0] lim;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  func = FN_REQUEST;
    logic [63:0] peer_key = '0;
    logic [31:0] now_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        accepted;
    logic [1:0]  denial;
    logic [15:0] retry_after_ms;
    logic [15:0] limit_hit;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_HTTP_CAP;
    logic [31:0] cfg_data = '0;

    peer_admission_policer_table_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .peer_key(peer_key), .now_ms(now_ms),
        .out_valid(out_valid), .out_stall(out_stall),
        .accepted(accepted), .denial(denial),
        .retry_after_ms(retry_after_ms), .limit_hit(limit_hit),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Register shadow
    logic [7:0]  http_cap, upg_cap;
    logic [15:0] http_rate, upg_rate;
    logic [9:0]  tcp_lim, ws_lim, ws_peer_lim;
    logic [31:0] idle_ms;

    // Peer table shadow
    logic        slot_used [TABLE_SLOTS];
    logic [63:0] slot_key  [TABLE_SLOTS];
    logic [31:0] slot_seen [TABLE_SLOTS];
    logic [9:0]  slot_tcp  [TABLE_SLOTS];
    logic [9:0]  slot_ws   [TABLE_SLOTS];
    logic [31:0] req_tok   [TABLE_SLOTS];
    logic [31:0] req_stamp [TABLE_SLOTS];
    logic [31:0] upg_tok   [TABLE_SLOTS];
    logic [31:0] upg_stamp [TABLE_SLOTS];
    logic [9:0]  tcp_total, ws_total;

    verdict_t    verdict_q[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic [31:0] clock_ms = '0;
    logic [63:0] key_pool [80];

    initial begin
        forever #4 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drive output backpressure
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each delivered result with the oldest expectation
    always @(posedge clk) begin
        verdict_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (verdict_q.size() == 0) begin
                $error("result with no expectation pending");
                fail_count++;
            end else begin
                want = verdict_q.pop_front();
                if (accepted !== want.acc) begin
                    $error("accepted: expected %0d actual %0d", want.acc, accepted);
                    fail_count++;
                end
                if (denial !== want.den) begin
                    $error("denial: expected %0d actual %0d", want.den, denial);
                    fail_count++;
                end
                if (retry_after_ms !== want.retry) begin
                    $error("retry_after_ms: expected %0d actual %0d", want.retry,
                           retry_after_ms);
                    fail_count++;
                end
                if (limit_hit !== want.lim) begin
                    $error("limit_hit: expected %0d actual %0d", want.lim, limit_hit);
                    fail_count++;
                end
            end
        end
    end

    function automatic verdict_t conn_denial(input logic [15:0] lim);
        verdict_t v;
        v.acc   = 1'b0;
        v.den   = DEN_CONN;
        v.retry = CONN_RETRY_MS;
        v.lim   = lim;
        return v;
    endfunction

    // Refill one bucket, then take a token or compute the retry wait
    function automatic verdict_t draw_token(inout logic [31:0] tok, inout logic [31:0] stamp,
                                            input logic [7:0] cap, input logic [15:0] rate,
                                            input logic [31:0] t);
        longint unsigned capq, gain, sum, num, den, wait_ms;
        verdict_t v;
        v = '0;
        capq = longint'(cap) << 16;
        if (t > stamp) begin
            gain = (longint'(t - stamp) * longint'(rate) * 256) / 1000;
            sum = longint'(tok) + gain;
            tok = (sum < capq) ? sum[31:0] : capq[31:0];
            stamp = t;
        end
        if (tok >= 32'h10000) begin
            tok = tok - 32'h10000;
            v.acc = 1'b1;
            v.den = DEN_NONE;
            return v;
        end
        wait_ms = RETRY_CAP;
        if (rate != 0) begin
            num = longint'(32'h10000 - tok) * 1000;
            den = longint'(rate) * 256;
            wait_ms = (num + den - 1) / den;
            if (wait_ms < 1) wait_ms = 1;
            if (wait_ms > RETRY_CAP) wait_ms = RETRY_CAP;
        end
        v.den   = DEN_RATE;
        v.retry = wait_ms[15:0];
        return v;
    endfunction

    function automatic int find_peer(input logic [63:0] k);
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (slot_used[i] && slot_key[i] == k) return i;
        return -1;
    endfunction

    // Find the peer, or place it in a free or evictable slot
    function automatic int claim_slot(input logic [63:0] k, input logic [31:0] t);
        int s;
        s = find_peer(k);
        if (s >= 0) begin
            slot_seen[s] = t;
            return s;
        end
        for (int i = 0; i < TABLE_SLOTS && s < 0; i++)
            if (!slot_used[i]) s = i;
        if (s < 0) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (slot_tcp[i] != 0 || slot_ws[i] != 0) continue;
                if (s < 0 || slot_seen[i] < slot_seen[s] ||
                    (slot_seen[i] == slot_seen[s] && slot_key[i] < slot_key[s]))
                    s = i;
            end
            if (s < 0) return -1;
        end
        slot_used[s] = 1'b1;
        slot_key[s]  = k;
        slot_seen[s] = t;
        slot_tcp[s]  = '0;
        slot_ws[s]   = '0;
        req_tok[s]   = {8'd0, http_cap, 16'd0};
        req_stamp[s] = t;
        upg_tok[s]   = {8'd0, upg_cap, 16'd0};
        upg_stamp[s] = t;
        return s;
    endfunction

    // Advance the table shadow by one event; returns 1 if it yields a result
    function automatic bit predict_admission(input logic [2:0] f, input logic [63:0] k,
                                             input logic [31:0] t, output verdict_t v);
        int s;
        v = '0;
        if (f == FN_CLOSE_TCP || f == FN_CLOSE_WS) begin
            s = find_peer(k);
            if (s < 0) return 0;
            slot_seen[s] = t;
            if (f == FN_CLOSE_TCP && slot_tcp[s] > 0) begin
                slot_tcp[s]--;
                if (tcp_total > 0) tcp_total--;
            end
            if (f == FN_CLOSE_WS && slot_ws[s] > 0) begin
                slot_ws[s]--;
                if (ws_total > 0) ws_total--;
            end
            return 0;
        end
        if (f == FN_SPARE_6 || f == FN_SPARE_7) return 0;
        // Drop idle connectionless peers
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (slot_used[i] && slot_tcp[i] == 0 && slot_ws[i] == 0 &&
                t >= slot_seen[i] && t - slot_seen[i] >= idle_ms)
                slot_used[i] = 1'b0;
        if (f == FN_OPEN_TCP && tcp_total >= tcp_lim) begin
            v = conn_denial(16'(tcp_lim));
            return 1;
        end
        s = claim_slot(k, t);
        if (s < 0) begin
            v = conn_denial(16'(TABLE_SLOTS));
            return 1;
        end
        case (f)
            FN_OPEN_TCP: begin
                slot_tcp[s]++;
                tcp_total++;
                v.acc = 1'b1;
            end
            FN_REQUEST: v = draw_token(req_tok[s], req_stamp[s], http_cap, http_rate, t);
            FN_UPGRADE: v = draw_token(upg_tok[s], upg_stamp[s], upg_cap, upg_rate, t);
            default: begin
                if (ws_total >= ws_lim) v = conn_denial(16'(ws_lim));
                else if (slot_ws[s] >= ws_peer_lim) v = conn_denial(16'(ws_peer_lim));
                else begin
                    slot_ws[s]++;
                    ws_total++;
                    v.acc = 1'b1;
                end
            end
        endcase
        return 1;
    endfunction

    // Send one item and record what it should produce
    task automatic send_event(input logic [2:0] f, input logic [63:0] k, input logic [31:0] t);
        verdict_t v;
        @(negedge clk);
        in_valid = 1'b1;
        func     = f;
        peer_key = k;
        now_ms   = t;
        do @(posedge clk); while (in_stall);
        if (predict_admission(f, k, t, v)) verdict_q.push_back(v);
        if ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // Wait for all results, then for any close still in flight
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_HTTP_CAP:  http_cap    = data[7:0];
            REG_HTTP_RATE: http_rate   = data[15:0];
            REG_UPG_CAP:   upg_cap     = data[7:0];
            REG_UPG_RATE:  upg_rate    = data[15:0];
            REG_TCP_TOT:   tcp_lim     = data[9:0];
            REG_WS_TOT:    ws_lim      = data[9:0];
            REG_WS_PEER:   ws_peer_lim = data[9:0];
            default:       idle_ms     = data;
        endcase
    endtask

    // Burst upgrades past capacity, then refill; then three requests to another peer
    task automatic test_buckets();
        for (int i = 0; i < 7; i++) send_event(FN_UPGRADE, 64'h0, 32'd0);
        send_event(FN_UPGRADE, 64'h0, 32'd1500);
        for (int i = 0; i < 3; i++) send_event(FN_REQUEST, 64'hFFFF_FFFF_FFFF_FFFF, 32'd10);
    endtask

    // Zero and maximum rate and capacity, extreme times, time going backwards
    task automatic test_extremes();
        drain();
        write_reg(REG_HTTP_CAP, 32'hFFFF_FF00);
        write_reg(REG_UPG_RATE, 32'h0);
        send_event(FN_REQUEST, 64'h5555_AAAA_0F0F_F0F0, 32'd100);
        send_event(FN_UPGRADE, 64'h0, 32'd5000);
        send_event(FN_UPGRADE, 64'h0, 32'd5000);
        drain();
        write_reg(REG_HTTP_CAP, 32'd255);
        write_reg(REG_HTTP_RATE, 32'hFFFF);
        write_reg(REG_UPG_RATE, 32'd1);
        send_event(FN_REQUEST, 64'h1234, 32'hFFFF_FFFF);
        send_event(FN_UPGRADE, 64'h0, 32'hFFFF_FFFF);
        send_event(FN_REQUEST, 64'h1234, 32'd20);
        send_event(FN_UPGRADE, 64'h0, 32'd30);
    endtask

    // Connection limits, closes of unknown or idle peers, unused codes
    task automatic test_connections();
        drain();
        write_reg(REG_TCP_TOT, 32'd0);
        write_reg(REG_WS_PEER, 32'd1);
        write_reg(REG_WS_TOT, 32'd2);
        send_event(FN_OPEN_TCP, 64'h77, 32'd40);
        send_event(FN_OPEN_WS, 64'h77, 32'd41);
        send_event(FN_OPEN_WS, 64'h77, 32'd42);
        send_event(FN_OPEN_WS, 64'h78, 32'd43);
        send_event(FN_OPEN_WS, 64'h79, 32'd44);
        send_event(FN_CLOSE_WS, 64'h77, 32'd45);
        send_event(FN_CLOSE_WS, 64'h77, 32'd46);
        send_event(FN_CLOSE_TCP, 64'hDEAD, 32'd47);
        send_event(FN_SPARE_6, 64'h77, 32'd48);
        send_event(FN_SPARE_7, 64'h77, 32'd48);
        send_event(FN_OPEN_WS, 64'h79, 32'd49);
    endtask

    // Fill the table with connected peers, then free two for eviction
    task automatic test_table_full();
        drain();
        write_reg(REG_TCP_TOT, 32'd1023);
        write_reg(REG_WS_TOT, 32'd1023);
        write_reg(REG_IDLE, 32'hFFFF_FFFF);
        for (int i = 0; i < TABLE_SLOTS; i++) send_event(FN_OPEN_TCP, 64'h100 + i, 32'd60);
        send_event(FN_REQUEST, 64'hBEEF, 32'd61);
        send_event(FN_CLOSE_TCP, 64'h105, 32'd61);
        send_event(FN_CLOSE_TCP, 64'h103, 32'd61);
        send_event(FN_REQUEST, 64'hBEEF, 32'd62);
        send_event(FN_REQUEST, 64'hBEF0, 32'd62);
        for (int i = 0; i < TABLE_SLOTS; i++) send_event(FN_CLOSE_TCP, 64'h100 + i, 32'd63);
        drain();
        write_reg(REG_IDLE, 32'd0);
        send_event(FN_REQUEST, 64'hBEF1, 32'd63);
    endtask

    // Random traffic over a small key pool, mostly moving forward in time
    task automatic test_random(input int n);
        int r, idx;
        logic [2:0] f;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 30)      f = FN_REQUEST;
            else if (r < 44) f = FN_UPGRADE;
            else if (r < 59) f = FN_OPEN_TCP;
            else if (r < 72) f = FN_CLOSE_TCP;
            else if (r < 84) f = FN_OPEN_WS;
            else if (r < 97) f = FN_CLOSE_WS;
            else             f = $urandom_range(1) ? FN_SPARE_6 : FN_SPARE_7;
            r = $urandom_range(99);
            if (r < 65)      clock_ms = clock_ms + $urandom_range(300);
            else if (r < 93) clock_ms = clock_ms;
            else if (r < 97) clock_ms = clock_ms + $urandom_range(200000, 60000);
            else if (clock_ms > 5000) clock_ms = clock_ms - $urandom_range(5000);
            idx = $urandom_range(($urandom_range(3) == 0) ? 79 : 40);
            send_event(f, key_pool[idx], clock_ms);
        end
    endtask

    // One random setting per phase, edges included
    task automatic randomize_regs(input bit tight);
        drain();
        write_reg(REG_HTTP_CAP, tight ? $urandom_range(3) : $urandom());
        write_reg(REG_HTTP_RATE, ($urandom_range(4) == 0) ? 32'hFFFF : $urandom_range(4000));
        write_reg(REG_UPG_CAP, $urandom_range(tight ? 2 : 255));
        write_reg(REG_UPG_RATE, $urandom_range(tight ? 300 : 65535));
        write_reg(REG_TCP_TOT, tight ? $urandom_range(20) : 32'd1023);
        write_reg(REG_WS_TOT, tight ? $urandom_range(10) : $urandom());
        write_reg(REG_WS_PEER, tight ? $urandom_range(3) : 32'd1023);
        write_reg(REG_IDLE, tight ? $urandom_range(100000, 20000) : 32'hFFFF_FFFF);
    endtask

    initial begin
        http_cap = 8'd20;  http_rate = 16'd2560;
        upg_cap  = 8'd5;   upg_rate  = 16'd256;
        tcp_lim  = 10'd256; ws_lim = 10'd128; ws_peer_lim = 10'd4;
        idle_ms  = 32'd60000;
        tcp_total = '0;
        ws_total  = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) slot_used[i] = 1'b0;
        key_pool[0] = 64'h0;
        key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int i = 2; i < 80; i++) key_pool[i] = {$urandom(), $urandom()};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_buckets();
        test_extremes();
        test_connections();
        test_table_full();

        clock_ms = 32'd1000;
        send_idle_pct = 27;
        recv_idle_pct = 80;
        randomize_regs(1'b1);
        test_random(700);
        send_idle_pct = 80;
        recv_idle_pct = 27;
        randomize_regs(1'b0);
        test_random(700);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        randomize_regs(1'b1);
        test_random(650);
        drain();

        if (fail_count == 0 && verdict_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
